// File: hw/rtl/pgv_pkg.sv
// Shared constants for the point gravity velocity update block.
package pgv_pkg;
    localparam int CHUNK_W = 32;  // multiplier partial-product slice
    localparam int GCONST_W = 32; // gravity constant register width
    localparam int MASS_W = 32;   // source mass width
    localparam int GM_W = GCONST_W + MASS_W;
endpackage

// File: hw/rtl/pgv_mul.sv
// Three-stage unsigned multiplier built from 32x32 partial products.
module pgv_mul
    import pgv_pkg::*;
#(
    parameter int A_WIDTH = 64,
    parameter int B_WIDTH = 64
) (
    input  logic                       i_clk,
    input  logic [A_WIDTH-1:0]         i_a,
    input  logic [B_WIDTH-1:0]         i_b,
    output logic [A_WIDTH+B_WIDTH-1:0] o_p
);
    localparam int NA = (A_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int NB = (B_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int AXW = NA * CHUNK_W;
    localparam int BXW = NB * CHUNK_W;
    localparam int ROWW = AXW + CHUNK_W;
    localparam int PXW = AXW + BXW;

    logic [AXW-1:0]       w_a;
    logic [BXW-1:0]       w_b;
    logic [2*CHUNK_W-1:0] r_pp [NB][NA];
    logic [ROWW-1:0]      n_row [NB];
    logic [ROWW-1:0]      r_row [NB];
    logic [PXW-1:0]       n_p;
    logic [PXW-1:0]       r_p;

    assign w_a = AXW'(i_a);
    assign w_b = BXW'(i_b);

    // row sums: one row per slice of b
    always_comb begin
        for (int ib = 0; ib < NB; ib++) begin
            n_row[ib] = '0;
            for (int ia = 0; ia < NA; ia++) begin
                n_row[ib] = n_row[ib] + (ROWW'(r_pp[ib][ia]) << (ia * CHUNK_W));
            end
        end
    end

    always_comb begin
        n_p = '0;
        for (int ib = 0; ib < NB; ib++) begin
            n_p = n_p + (PXW'(r_row[ib]) << (ib * CHUNK_W));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ib = 0; ib < NB; ib++) begin
            for (int ia = 0; ia < NA; ia++) begin
                r_pp[ib][ia] <= w_a[ia*CHUNK_W +: CHUNK_W] * w_b[ib*CHUNK_W +: CHUNK_W];
            end
            r_row[ib] <= n_row[ib];
        end
        r_p <= n_p;
    end

    assign o_p = r_p[A_WIDTH+B_WIDTH-1:0];
endmodule

// File: hw/rtl/pgv_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
module pgv_div
    import pgv_pkg::*;
#(
    parameter int NUM_WIDTH = 128,
    parameter int DEN_WIDTH = 147,
    parameter int Q_WIDTH = 49
) (
    input  logic                 i_clk,
    input  logic [NUM_WIDTH-1:0] i_num,
    input  logic [DEN_WIDTH-1:0] i_den,
    output logic [Q_WIDTH-1:0]   o_q
);
    localparam int HW = NUM_WIDTH - Q_WIDTH;
    localparam int MW = (HW > DEN_WIDTH) ? HW : DEN_WIDTH;

    logic [MW-1:0]        w_hi;
    logic                 w_huge;
    logic                 r_huge [Q_WIDTH+1];
    logic [DEN_WIDTH-1:0] r_rem  [Q_WIDTH+1];
    logic [Q_WIDTH-1:0]   r_q    [Q_WIDTH+1];
    logic [DEN_WIDTH-1:0] r_den  [Q_WIDTH];
    logic [Q_WIDTH-1:0]   r_lo   [Q_WIDTH];
    logic [DEN_WIDTH-1:0] n_rem  [1:Q_WIDTH];
    logic [Q_WIDTH-1:0]   n_q    [1:Q_WIDTH];

    // quotient needs more than Q_WIDTH bits when the top part reaches den
    assign w_hi = MW'(i_num >> Q_WIDTH);
    assign w_huge = (w_hi >= MW'(i_den));

    always_comb begin
        logic [DEN_WIDTH:0] t;
        logic [DEN_WIDTH:0] d;
        for (int k = 1; k <= Q_WIDTH; k++) begin
            t = {r_rem[k-1], r_lo[k-1][Q_WIDTH-k]};
            d = {1'b0, r_den[k-1]};
            if (t >= d) begin
                n_rem[k] = DEN_WIDTH'(t - d);
                n_q[k] = {r_q[k-1][Q_WIDTH-2:0], 1'b1};
            end else begin
                n_rem[k] = t[DEN_WIDTH-1:0];
                n_q[k] = {r_q[k-1][Q_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_huge[0] <= w_huge;
        r_rem[0] <= DEN_WIDTH'(w_hi);
        r_q[0] <= '0;
        r_den[0] <= i_den;
        r_lo[0] <= i_num[Q_WIDTH-1:0];
        for (int k = 1; k <= Q_WIDTH; k++) begin
            r_huge[k] <= r_huge[k-1];
            r_rem[k] <= n_rem[k];
            r_q[k] <= n_q[k];
        end
        for (int k = 1; k < Q_WIDTH; k++) begin
            r_den[k] <= r_den[k-1];
            r_lo[k] <= r_lo[k-1];
        end
    end

    assign o_q = r_huge[Q_WIDTH] ? '1 : r_q[Q_WIDTH];
endmodule

// File: hw/rtl/point_gravity_velocity_update.sv
// Point-mass gravity velocity update: v + G*m*d/|d|^3, fully pipelined.
// The result passes through the bit-per-stage square root and divider pipelines.
// Throughput: one request per cycle, busy is never raised; the receiver cannot stall.
// Reset: synchronous active-low; clears the valid line, gravity constant returns to 1.
module point_gravity_velocity_update
    import pgv_pkg::*;
#(
    parameter int COORD_WIDTH = 48,
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [GCONST_W-1:0]    i_cfg_wdata,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_WIDTH-1:0] i_target_x,
    input  logic [COORD_WIDTH-1:0] i_target_y,
    input  logic [COORD_WIDTH-1:0] i_target_z,
    input  logic [COORD_WIDTH-1:0] i_source_x,
    input  logic [COORD_WIDTH-1:0] i_source_y,
    input  logic [COORD_WIDTH-1:0] i_source_z,
    input  logic [MASS_W-1:0]      i_source_mass,
    input  logic [COORD_WIDTH-1:0] i_vel_in_x,
    input  logic [COORD_WIDTH-1:0] i_vel_in_y,
    input  logic [COORD_WIDTH-1:0] i_vel_in_z,
    output logic                   o_valid,
    output logic [COORD_WIDTH-1:0] o_vel_out_x,
    output logic [COORD_WIDTH-1:0] o_vel_out_y,
    output logic [COORD_WIDTH-1:0] o_vel_out_z,
    output logic                   o_coincident,
    output logic                   o_saturated
);
    localparam int CW = COORD_WIDTH;
    localparam int SW = 2 * CW + 2;            // |d|^2
    localparam int RW = CW + 1;                // isqrt(|d|^2), one bit per stage
    localparam int QW = CW + 1;                // quotient bits kept
    localparam int E = 3 * FRAC_BITS - 32;     // fixed-point alignment
    localparam int SH_NUM = (E >= 0) ? E : 0;
    localparam int SH_DEN = (E < 0) ? -E : 0;
    localparam int PW = GM_W + CW;             // G*m*|d_k|
    localparam int NUMW = PW + SH_NUM;
    localparam int DPW = SW + RW;              // s*r
    localparam int DENW = DPW + SH_DEN;
    localparam int ND = 4 + RW;                // numerator wait for denominator
    localparam int AF = 2 * CW + 12;           // age of the output register
    localparam int SDW = 3 * CW + 3;
    localparam int NSD = AF - 1;
    localparam int NCD = AF - 6;
    localparam int SUMW = CW + 3;
    localparam logic [SUMW-1:0] LIM_HI = {{4{1'b0}}, {(CW-1){1'b1}}};
    localparam logic [SUMW-1:0] LIM_LO = {{4{1'b1}}, {(CW-1){1'b0}}};

    // valid line and config register
    logic [AF:0]         r_vld;
    logic [GCONST_W-1:0] r_gconst;

    // age 0: captured request
    logic [CW-1:0]     r0_t [3];
    logic [CW-1:0]     r0_s [3];
    logic [CW-1:0]     r0_v [3];
    logic [MASS_W-1:0] r0_m;

    // age 1: separation magnitude/sign, G*m
    logic [CW:0]   w_d  [3];
    logic [CW-1:0] n1_dm [3];
    logic [2:0]    n1_dn;
    logic [CW-1:0] r1_dm [3];
    logic [GM_W-1:0] w_gm;
    logic [GM_W-1:0] r1_gm;

    // age 4 multiplier outputs, age 5 sum of squares
    logic [2*CW-1:0] w_sq  [3];
    logic [PW-1:0]   w_num [3];
    logic [SW-1:0]   w_s;
    logic [SW-1:0]   r5_s;
    logic            r5_coin;

    // delay lines
    logic [PW-1:0]  r_num_dly [ND][3];
    logic [SDW-1:0] r_side_dly [NSD];
    logic           r_coin_dly [NCD];

    // square root stages
    logic [SW-1:0]   r_sq_s    [RW];
    logic [RW+1:0]   r_sq_rem  [RW];
    logic [RW-1:0]   r_sq_root [RW];
    logic [RW+1:0]   n_sq_rem  [RW];
    logic [RW-1:0]   n_sq_root [RW];

    // denominator and quotients
    logic [DPW-1:0]  w_den_p;
    logic [DENW-1:0] w_den;
    logic [QW-1:0]   w_q [3];

    // output stage
    logic [CW-1:0] n_out [3];
    logic [2:0]    n_sat;
    logic [CW-1:0] r_out [3];
    logic          r_coin_o;
    logic          r_sat_o;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_gconst <= GCONST_W'(1);
        end else begin
            r_vld <= {r_vld[AF-1:0], start};
            if (i_cfg_we) begin
                r_gconst <= i_cfg_wdata;
            end
        end
    end

    // age 0 capture
    always_ff @(posedge i_clk) begin
        r0_t[0] <= i_target_x;
        r0_t[1] <= i_target_y;
        r0_t[2] <= i_target_z;
        r0_s[0] <= i_source_x;
        r0_s[1] <= i_source_y;
        r0_s[2] <= i_source_z;
        r0_v[0] <= i_vel_in_x;
        r0_v[1] <= i_vel_in_y;
        r0_v[2] <= i_vel_in_z;
        r0_m <= i_source_mass;
    end

    // d = source - target, kept as sign and magnitude
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k] = {r0_s[k][CW-1], r0_s[k]} - {r0_t[k][CW-1], r0_t[k]};
            n1_dn[k] = w_d[k][CW];
            n1_dm[k] = w_d[k][CW] ? CW'(-w_d[k]) : w_d[k][CW-1:0];
        end
    end

    assign w_gm = r_gconst * r0_m;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_dm[k] <= n1_dm[k];
        end
        r1_gm <= w_gm;
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane_mul
        pgv_mul #(.A_WIDTH(CW), .B_WIDTH(CW)) u_sq (
            .i_clk (i_clk),
            .i_a   (r1_dm[k]),
            .i_b   (r1_dm[k]),
            .o_p   (w_sq[k])
        );
        pgv_mul #(.A_WIDTH(GM_W), .B_WIDTH(CW)) u_num (
            .i_clk (i_clk),
            .i_a   (r1_gm),
            .i_b   (r1_dm[k]),
            .o_p   (w_num[k])
        );
    end

    assign w_s = SW'(w_sq[0]) + SW'(w_sq[1]) + SW'(w_sq[2]);

    always_ff @(posedge i_clk) begin
        r5_s <= w_s;
        r5_coin <= (w_s == '0);
    end

    // velocity and direction signs ride alongside the arithmetic
    always_ff @(posedge i_clk) begin
        r_side_dly[0] <= {r0_v[2], r0_v[1], r0_v[0], n1_dn};
        for (int i = 1; i < NSD; i++) begin
            r_side_dly[i] <= r_side_dly[i-1];
        end
        r_coin_dly[0] <= r5_coin;
        for (int i = 1; i < NCD; i++) begin
            r_coin_dly[i] <= r_coin_dly[i-1];
        end
        for (int k = 0; k < 3; k++) begin
            r_num_dly[0][k] <= w_num[k];
            for (int i = 1; i < ND; i++) begin
                r_num_dly[i][k] <= r_num_dly[i-1][k];
            end
        end
    end

    // integer square root, two radicand bits per stage
    always_comb begin
        logic [SW-1:0] s_in;
        logic [RW+1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [RW+3:0] t;
        logic [RW+3:0] trial;
        for (int j = 0; j < RW; j++) begin
            if (j == 0) begin
                s_in = r5_s;
                rem_in = '0;
                root_in = '0;
            end else begin
                s_in = r_sq_s[j-1];
                rem_in = r_sq_rem[j-1];
                root_in = r_sq_root[j-1];
            end
            t = {rem_in, s_in[SW-2-2*j +: 2]};
            trial = (RW+4)'({root_in, 2'b01});
            if (t >= trial) begin
                n_sq_rem[j] = (RW+2)'(t - trial);
                n_sq_root[j] = {root_in[RW-2:0], 1'b1};
            end else begin
                n_sq_rem[j] = t[RW+1:0];
                n_sq_root[j] = {root_in[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_s[0] <= r5_s;
        for (int j = 1; j < RW; j++) begin
            r_sq_s[j] <= r_sq_s[j-1];
        end
        for (int j = 0; j < RW; j++) begin
            r_sq_rem[j] <= n_sq_rem[j];
            r_sq_root[j] <= n_sq_root[j];
        end
    end

    // denominator s*r, scaled when the fixed-point alignment is negative
    pgv_mul #(.A_WIDTH(SW), .B_WIDTH(RW)) u_den (
        .i_clk (i_clk),
        .i_a   (r_sq_s[RW-1]),
        .i_b   (r_sq_root[RW-1]),
        .o_p   (w_den_p)
    );

    assign w_den = DENW'(w_den_p) << SH_DEN;

    for (genvar k = 0; k < 3; k++) begin : g_lane_div
        pgv_div #(.NUM_WIDTH(NUMW), .DEN_WIDTH(DENW), .Q_WIDTH(QW)) u_div (
            .i_clk (i_clk),
            .i_num (NUMW'(r_num_dly[ND-1][k]) << SH_NUM),
            .i_den (w_den),
            .o_q   (w_q[k])
        );
    end

    // apply signed acceleration and clip to the coordinate range
    always_comb begin
        logic [SUMW-1:0] v;
        logic [SUMW-1:0] q;
        logic [SUMW-1:0] sum;
        for (int k = 0; k < 3; k++) begin
            v = SUMW'($signed(r_side_dly[NSD-1][3+CW*k +: CW]));
            q = SUMW'(w_q[k]);
            sum = r_side_dly[NSD-1][k] ? (v - q) : (v + q);
            n_sat[k] = 1'b0;
            if ($signed(sum) > $signed(LIM_HI)) begin
                n_out[k] = LIM_HI[CW-1:0];
                n_sat[k] = 1'b1;
            end else if ($signed(sum) < $signed(LIM_LO)) begin
                n_out[k] = LIM_LO[CW-1:0];
                n_sat[k] = 1'b1;
            end else begin
                n_out[k] = sum[CW-1:0];
            end
            // coincident positions: velocity passes untouched
            if (r_coin_dly[NCD-1]) begin
                n_out[k] = v[CW-1:0];
                n_sat[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_out[k] <= n_out[k];
        end
        r_coin_o <= r_coin_dly[NCD-1];
        r_sat_o <= |n_sat;
    end

    assign o_valid = r_vld[AF];
    assign o_vel_out_x = r_out[0];
    assign o_vel_out_y = r_out[1];
    assign o_vel_out_z = r_out[2];
    assign o_coincident = r_coin_o;
    assign o_saturated = r_sat_o;
endmodule

// File: tb/tb_point_gravity_velocity_update.sv
// Testbench for the point gravity velocity update block: directed table plus random pairs.
`timescale 1ns / 100ps

module tb_point_gravity_velocity_update;
    import pgv_pkg::*;

    localparam int CW = 48;
    localparam int FB = 16;
    localparam int LATENCY = 2 * CW + 12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS = 130;
    localparam logic signed [73:0] VEL_MAX = (74'sd1 <<< (CW - 1)) - 74'sd1;
    localparam logic signed [73:0] VEL_MIN = -(74'sd1 <<< (CW - 1));
    localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] POS_MIN = {1'b1, {(CW-1){1'b0}}};

    // One pair request: target position, source position and mass, target velocity.
    typedef struct packed {
        logic [2:0][CW-1:0]   tgt;
        logic [2:0][CW-1:0]   src;
        logic [MASS_W-1:0]    mass;
        logic [2:0][CW-1:0]   vel;
    } pair_req_t;

    typedef struct packed {
        logic [2:0][CW-1:0] vel;
        logic               coin;
        logic               sat;
    } vel_upd_t;

    typedef struct {
        pair_req_t req;
        bit        known;
        vel_upd_t  upd;
    } table_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [GCONST_W-1:0] i_cfg_wdata = '0;
    logic start = 1'b0;
    logic busy;
    pair_req_t cur_req = '0;
    bit cur_known = 1'b0;
    vel_upd_t cur_upd = '0;
    logic o_valid, o_coincident, o_saturated;
    logic [CW-1:0] o_vel_out_x, o_vel_out_y, o_vel_out_z;

    logic [GCONST_W-1:0] g_shadow;  // predictor's copy of the gravity constant
    vel_upd_t upd_q[$];             // expected velocity updates, oldest first
    table_row_t dir_rows[$];
    int err_count = 0;
    int idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    point_gravity_velocity_update #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .start        (start),
        .busy         (busy),
        .i_target_x   (cur_req.tgt[0]),
        .i_target_y   (cur_req.tgt[1]),
        .i_target_z   (cur_req.tgt[2]),
        .i_source_x   (cur_req.src[0]),
        .i_source_y   (cur_req.src[1]),
        .i_source_z   (cur_req.src[2]),
        .i_source_mass(cur_req.mass),
        .i_vel_in_x   (cur_req.vel[0]),
        .i_vel_in_y   (cur_req.vel[1]),
        .i_vel_in_z   (cur_req.vel[2]),
        .o_valid      (o_valid),
        .o_vel_out_x  (o_vel_out_x),
        .o_vel_out_y  (o_vel_out_y),
        .o_vel_out_z  (o_vel_out_z),
        .o_coincident (o_coincident),
        .o_saturated  (o_saturated)
    );

    // Exact-integer velocity update: v + trunc(G*m*d_k*2^(3F-32) / (s*floor(sqrt(s)))).
    function automatic vel_upd_t gravity_kick(pair_req_t p, logic [GCONST_W-1:0] g);
        logic signed [49:0] d[3];
        logic [255:0] s, r, c, den, base, mag, q;
        logic signed [73:0] sum, kick;
        vel_upd_t o;
        int k, i;
        s = '0;
        for (k = 0; k < 3; k++) begin
            d[k] = $signed({{2{p.src[k][CW-1]}}, p.src[k]})
                 - $signed({{2{p.tgt[k][CW-1]}}, p.tgt[k]});
            mag = 256'(d[k] < 0 ? -d[k] : d[k]);
            s = s + mag * mag;
        end
        o.coin = 1'b0;
        o.sat = 1'b0;
        // same position: no force, velocity passes through
        if (s == 0) begin
            o.vel = p.vel;
            o.coin = 1'b1;
            return o;
        end
        r = '0;
        for (i = 63; i >= 0; i--) begin
            c = r | (256'd1 << i);
            if (c * c <= s) r = c;
        end
        den = s * r;
        base = (256'(g) * 256'(p.mass)) << (3 * FB - 32);
        for (k = 0; k < 3; k++) begin
            mag = 256'(d[k] < 0 ? -d[k] : d[k]);
            q = (base * mag) / den;
            if (q[255:64] != 0) begin
                o.sat = 1'b1;
                o.vel[k] = d[k] < 0 ? POS_MIN : POS_MAX;
            end else begin
                kick = $signed({10'b0, q[63:0]});
                if (d[k] < 0) kick = -kick;
                sum = $signed({{26{p.vel[k][CW-1]}}, p.vel[k]}) + kick;
                if (sum > VEL_MAX) begin
                    o.sat = 1'b1;
                    o.vel[k] = POS_MAX;
                end else if (sum < VEL_MIN) begin
                    o.sat = 1'b1;
                    o.vel[k] = POS_MIN;
                end else begin
                    o.vel[k] = sum[CW-1:0];
                end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        err_count++;
    endtask

    // Request capture and result checking, both on the sampled values of this edge.
    always @(posedge i_clk) begin
        vel_upd_t want;
        if (!i_rst_n) begin
            g_shadow <= 32'd1;
        end else begin
            if (start && !busy)
                upd_q.push_back(cur_known ? cur_upd : gravity_kick(cur_req, g_shadow));
            if (i_cfg_we)
                g_shadow <= i_cfg_wdata;
            if (o_valid) begin
                if (upd_q.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    err_count++;
                end else begin
                    want = upd_q.pop_front();
                    if (o_vel_out_x !== want.vel[0])
                        report_mismatch("vel_out_x", o_vel_out_x, want.vel[0]);
                    if (o_vel_out_y !== want.vel[1])
                        report_mismatch("vel_out_y", o_vel_out_y, want.vel[1]);
                    if (o_vel_out_z !== want.vel[2])
                        report_mismatch("vel_out_z", o_vel_out_z, want.vel[2]);
                    if (o_coincident !== want.coin)
                        report_mismatch("coincident", CW'(o_coincident), CW'(want.coin));
                    if (o_saturated !== want.sat)
                        report_mismatch("saturated", CW'(o_saturated), CW'(want.sat));
                end
            end
        end
        // watchdog: cycles with no request taken and no result delivered
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        return CW'({$urandom, $urandom});
    endfunction

    // Mostly a target with a nearby source at a random scale; some full noise, some coincident.
    function automatic pair_req_t rand_pair();
        pair_req_t p;
        logic [CW-1:0] off;
        int kind, k, sh;
        kind = $urandom_range(0, 9);
        for (k = 0; k < 3; k++) begin
            p.tgt[k] = rand_coord();
            p.vel[k] = rand_coord();
            if ($urandom_range(0, 5) == 0)
                p.vel[k] = $urandom_range(0, 1) ? POS_MAX - CW'($urandom_range(0, 3))
                                                : POS_MIN + CW'($urandom_range(0, 3));
            else if ($urandom_range(0, 2) == 0)
                p.vel[k] = CW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            sh = $urandom_range(0, 44);
            off = rand_coord() >> (CW - 1 - sh);
            if ($urandom_range(0, 1)) off = -off;
            if ($urandom_range(0, 7) == 0) off = '0;
            if (kind == 0)
                p.src[k] = rand_coord();
            else if (kind == 1)
                p.src[k] = p.tgt[k];
            else
                p.src[k] = p.tgt[k] + off;
        end
        case ($urandom_range(0, 7))
            0: p.mass = '0;
            1: p.mass = '1;
            2: p.mass = MASS_W'($urandom_range(0, 255));
            default: p.mass = $urandom;
        endcase
        return p;
    endfunction

    // Sender: random gap before each request, start held high across back-to-back requests.
    task automatic send_pair(pair_req_t p, bit known, vel_upd_t u, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        cur_req <= p;
        cur_known <= known;
        cur_upd <= u;
        do @(posedge i_clk); while (busy);
    endtask

    // Drain everything in flight, then allow the pipeline to empty fully.
    task automatic settle();
        while (upd_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic add_row(pair_req_t p, bit known, vel_upd_t u);
        table_row_t t;
        t.req = p;
        t.known = known;
        t.upd = u;
        dir_rows.push_back(t);
    endtask

    initial begin
        pair_req_t p;
        vel_upd_t u;
        logic [GCONST_W-1:0] g_list[8];
        int ph, n, no_gap;

        // directed rows, run with the reset value of the gravity constant
        p = '0;
        u = '0;
        u.coin = 1'b1;
        add_row(p, 1'b1, u);                          // all zero: coincident
        p.tgt = {3{POS_MAX}}; p.src = {3{POS_MAX}}; p.vel = {3{POS_MIN}}; p.mass = '1;
        u.vel = p.vel;
        add_row(p, 1'b1, u);                          // coincident at the corner
        p.tgt = {3{POS_MIN}}; p.src = {3{POS_MIN}}; p.vel = {POS_MAX, POS_MIN, POS_MAX};
        u.vel = p.vel;
        add_row(p, 1'b1, u);
        // zero mass: no kick, not coincident
        p.tgt = '0; p.src = {POS_MAX, POS_MIN, CW'(1)}; p.mass = '0;
        p.vel = {CW'(5), POS_MIN, POS_MAX};
        u.vel = p.vel; u.coin = 1'b0; u.sat = 1'b0;
        add_row(p, 1'b1, u);
        // widest separation, largest mass
        p.tgt = {3{POS_MIN}}; p.src = {3{POS_MAX}}; p.mass = '1; p.vel = '0;
        add_row(p, 1'b0, u);
        p.tgt = {3{POS_MAX}}; p.src = {3{POS_MIN}};
        add_row(p, 1'b0, u);
        // one LSB apart on a single axis, max mass: kick overflows a velocity near the limit
        p.tgt = '0; p.src = {CW'(0), CW'(0), CW'(1)}; p.vel = {3{POS_MAX}};
        add_row(p, 1'b0, u);
        p.src = {CW'(0), CW'(0), -CW'(1)}; p.vel = {3{POS_MIN}};
        add_row(p, 1'b0, u);
        p.src = {CW'(1), -CW'(1), CW'(0)}; p.vel = '0;
        add_row(p, 1'b0, u);
        // one unit apart on every axis, mid masses
        p.src = {3{CW'(1) << FB}}; p.mass = 32'd1 << 16;
        add_row(p, 1'b0, u);
        p.src = {3{-(CW'(1) << FB)}}; p.mass = 32'd12345; p.vel = {POS_MAX, POS_MIN, CW'(7)};
        add_row(p, 1'b0, u);
        p.tgt = {POS_MAX, POS_MIN, POS_MAX}; p.src = {POS_MAX - 1, POS_MIN + 1, POS_MAX};
        p.mass = '1;
        add_row(p, 1'b0, u);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_pair(dir_rows[i].req, dir_rows[i].known, dir_rows[i].upd,
                      $urandom_range(0, 8));
        start <= 1'b0;
        cur_known <= 1'b0;

        g_list[0] = '0;
        g_list[1] = '1;
        g_list[2] = 32'd1;
        g_list[3] = $urandom;
        g_list[4] = 32'h0001_0000;
        g_list[5] = $urandom;
        g_list[6] = 32'h8000_0000;
        g_list[7] = $urandom_range(0, 1023);

        for (ph = 0; ph < 8; ph++) begin
            settle();
            i_cfg_we <= 1'b1;
            i_cfg_wdata <= g_list[ph];
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            no_gap = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                p = rand_pair();
                send_pair(p, 1'b0, u, no_gap ? 0 : $urandom_range(0, 8));
                // occasionally switch between back-to-back requests and gapped ones within a phase
                if ($urandom_range(0, 40) == 0) no_gap = !no_gap;
            end
            start <= 1'b0;
        end

        settle();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
